@@ src/fsac_pkg.sv @@
// Shared types and constants for the flag store accumulator unit.
// Request and response payload layouts, opcodes, and the flag write port.
// No dependencies.
package fsac_pkg;

   localparam int DATA_W      = 16;
   localparam int COORD_W     = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [DATA_W-1:0] LIFE_AT_RESET = 16'd100;

   typedef enum logic [3:0] {
      OP_SET           = 4'd0,
      OP_COPY          = 4'd1,
      OP_FLAG_FROM_ACC = 4'd2,
      OP_ACC_FROM_FLAG = 4'd3,
      OP_INC           = 4'd4,
      OP_ADD           = 4'd5,
      OP_SUB           = 4'd6,
      OP_TEST          = 4'd7,
      OP_CLEAR_ACC     = 4'd8,
      OP_ADD_ACC       = 4'd9,
      OP_SUB_ACC       = 4'd10,
      OP_ACC_FROM_LIFE = 4'd11,
      OP_CHANGE_LIFE   = 4'd12,
      OP_KILL          = 4'd13,
      OP_READ          = 4'd14
   } opcode_type;

   // last member in the lowest bits
   typedef struct packed {
      logic [3:0]              pad;
      logic signed [DATA_W-1:0] imm;
      logic [COORD_W-1:0]      src_y;
      logic [COORD_W-1:0]      src_x;
      logic [COORD_W-1:0]      dst_y;
      logic [COORD_W-1:0]      dst_x;
      opcode_type              req_type;
   } request_type;

   typedef struct packed {
      logic [3:0]               pad;
      logic                     player_alive;
      logic signed [DATA_W-1:0] read_value;
      logic                     acc_negative;
      logic                     acc_positive;
      logic                     acc_zero;
      logic signed [DATA_W-1:0] acc_value;
   } result_type;

   typedef struct packed {
      logic               en;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DATA_W-1:0]  data;
   } cell_wr_type;

endpackage

@@ src/fsac_flag_mem.sv @@
// Flag store: one write port, two registered read ports with write forwarding.
// Clears itself after reset, one cell per cycle. Depends on fsac_pkg.
module fsac_flag_mem #(
   parameter int X_CELLS = 16,
   parameter int Y_CELLS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [fsac_pkg::COORD_W-1:0]  rd_dst_x,
   input  logic [fsac_pkg::COORD_W-1:0]  rd_dst_y,
   input  logic [fsac_pkg::COORD_W-1:0]  rd_src_x,
   input  logic [fsac_pkg::COORD_W-1:0]  rd_src_y,
   input  fsac_pkg::cell_wr_type         wr,
   output logic                          busy,
   output logic [fsac_pkg::DATA_W-1:0]   dst_data,
   output logic [fsac_pkg::DATA_W-1:0]   src_data
);

   localparam int DEPTH = X_CELLS * Y_CELLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW    = AW + 9;

   function automatic logic cell_ok(input logic [fsac_pkg::COORD_W-1:0] x,
                                    input logic [fsac_pkg::COORD_W-1:0] y);
      cell_ok = (32'(x) < X_CELLS) && (32'(y) < Y_CELLS);
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [fsac_pkg::COORD_W-1:0] x,
                                               input logic [fsac_pkg::COORD_W-1:0] y);
      logic [MW-1:0] wide;
      wide      = MW'(x) * MW'(Y_CELLS) + MW'(y);
      cell_addr = wide[AW-1:0];
   endfunction

   logic [fsac_pkg::DATA_W-1:0] mem [DEPTH];

   logic                        clr_busy_ff;
   logic [AW-1:0]               clr_addr_ff;
   logic [fsac_pkg::DATA_W-1:0] mem_dst_ff, mem_src_ff;
   logic [fsac_pkg::DATA_W-1:0] fwd_data_ff;
   logic                        dst_ok_ff, src_ok_ff;
   logic                        dst_fwd_ff, src_fwd_ff;

   logic                        wr_ok;
   logic [AW-1:0]               wr_addr, dst_addr, src_addr;

   assign wr_ok    = wr.en && cell_ok(wr.x, wr.y);
   assign wr_addr  = cell_addr(wr.x, wr.y);
   assign dst_addr = cell_addr(rd_dst_x, rd_dst_y);
   assign src_addr = cell_addr(rd_src_x, rd_src_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_ok) begin
         mem[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         mem_dst_ff  <= mem[dst_addr];
         mem_src_ff  <= mem[src_addr];
         fwd_data_ff <= wr.data;
         dst_ok_ff   <= cell_ok(rd_dst_x, rd_dst_y);
         src_ok_ff   <= cell_ok(rd_src_x, rd_src_y);
         // a write landing in the same cycle is not yet in the read data
         dst_fwd_ff  <= wr.en && (wr.x == rd_dst_x) && (wr.y == rd_dst_y);
         src_fwd_ff  <= wr.en && (wr.x == rd_src_x) && (wr.y == rd_src_y);
      end
   end

   assign busy     = clr_busy_ff;
   assign dst_data = !dst_ok_ff ? '0 : (dst_fwd_ff ? fwd_data_ff : mem_dst_ff);
   assign src_data = !src_ok_ff ? '0 : (src_fwd_ff ? fwd_data_ff : mem_src_ff);

endmodule

@@ src/fsac_exec.sv @@
// Execute stage: accumulator and life counter registers, opcode decode,
// flag write-back and result formation. Depends on fsac_pkg.
module fsac_exec (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  fsac_pkg::request_type       req,
   input  logic [fsac_pkg::DATA_W-1:0] dst_data,
   input  logic [fsac_pkg::DATA_W-1:0] src_data,
   output fsac_pkg::cell_wr_type       wr,
   output fsac_pkg::result_type        result
);

   logic [fsac_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic [fsac_pkg::DATA_W-1:0] life_ff, life_in;
   logic [fsac_pkg::DATA_W-1:0] rd_value;
   logic [fsac_pkg::DATA_W-1:0] imm;
   logic                        wr_req;

   assign imm = req.imm;

   always_comb begin
      acc_in   = acc_ff;
      life_in  = life_ff;
      rd_value = '0;
      wr_req   = 1'b0;
      wr.x     = req.dst_x;
      wr.y     = req.dst_y;
      wr.data  = imm;
      case (req.req_type)
         fsac_pkg::OP_SET: begin
            wr_req = 1'b1;
         end
         fsac_pkg::OP_COPY: begin
            wr_req  = 1'b1;
            wr.data = src_data;
         end
         fsac_pkg::OP_FLAG_FROM_ACC: begin
            wr_req  = 1'b1;
            wr.data = acc_ff;
         end
         fsac_pkg::OP_ACC_FROM_FLAG: acc_in = src_data;
         fsac_pkg::OP_INC: begin
            wr_req  = 1'b1;
            wr.data = dst_data + imm;
         end
         fsac_pkg::OP_ADD: begin
            wr_req  = 1'b1;
            wr.data = dst_data + src_data;
         end
         fsac_pkg::OP_SUB: begin
            wr_req  = 1'b1;
            wr.data = dst_data - src_data;
         end
         fsac_pkg::OP_TEST:         acc_in   = dst_data - src_data;
         fsac_pkg::OP_CLEAR_ACC:    acc_in   = '0;
         fsac_pkg::OP_ADD_ACC:      acc_in   = acc_ff + imm;
         fsac_pkg::OP_SUB_ACC:      acc_in   = acc_ff - imm;
         fsac_pkg::OP_ACC_FROM_LIFE: acc_in  = life_ff;
         fsac_pkg::OP_CHANGE_LIFE:  life_in  = life_ff + imm;
         fsac_pkg::OP_KILL:         life_in  = '0;
         fsac_pkg::OP_READ:         rd_value = src_data;
         default: ;
      endcase
      wr.en = fire && wr_req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         life_ff <= fsac_pkg::LIFE_AT_RESET;
      end else if (fire) begin
         acc_ff  <= acc_in;
         life_ff <= life_in;
      end
   end

   always_comb begin
      result              = '0;
      result.acc_value    = acc_in;
      result.acc_zero     = (acc_in == '0);
      result.acc_positive = (acc_in != '0) && !acc_in[fsac_pkg::DATA_W-1];
      result.acc_negative = acc_in[fsac_pkg::DATA_W-1];
      result.read_value   = rd_value;
      result.player_alive = (life_in != '0) && !life_in[fsac_pkg::DATA_W-1];
   end

endmodule

@@ src/flag_store_accumulator_unit.sv @@
// Top level of the flag store accumulator unit: stream ports, execute and
// response registers. Depends on fsac_pkg, fsac_flag_mem and fsac_exec.
//
// One request per cycle is accepted when the response side keeps up; each
// request gives one response after its transfer, by way of the flag read and
// then the execute into the response register. The rate is set by the single
// read-modify-write per request on the flag memory (two read ports, one
// write port, write data forwarded to a read of the same cell). After reset
// the flag memory is cleared one cell per cycle, and req_tready stays low
// until that pass is done. Cells at or beyond X_CELLS or Y_CELLS read as
// zero and ignore writes.
module flag_store_accumulator_unit #(
   parameter int X_CELLS = 16,
   parameter int Y_CELLS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_type[3:0], dst_x[7:4], dst_y[11:8], src_x[15:12], src_y[19:16], imm[35:20]
   input  logic [fsac_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // acc_value[15:0], acc_zero[16], acc_positive[17], acc_negative[18],
   // read_value[34:19], player_alive[35]
   output logic [fsac_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   fsac_pkg::request_type       req;
   fsac_pkg::request_type       exe_req_ff;
   logic                        exe_valid_ff;
   logic                        rsp_valid_ff;
   fsac_pkg::result_type        rsp_data_ff;
   fsac_pkg::result_type        result;
   fsac_pkg::cell_wr_type       wr;
   logic                        busy;
   logic                        req_fire;
   logic                        exe_fire;
   logic [fsac_pkg::DATA_W-1:0] dst_data, src_data;

   assign req        = fsac_pkg::request_type'(req_tdata);
   assign exe_fire   = exe_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy && (!exe_valid_ff || exe_fire);
   assign req_fire   = req_tvalid && req_tready;

   fsac_flag_mem #(
      .X_CELLS (X_CELLS),
      .Y_CELLS (Y_CELLS)
   ) u_flag_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_dst_x (req.dst_x),
      .rd_dst_y (req.dst_y),
      .rd_src_x (req.src_x),
      .rd_src_y (req.src_y),
      .wr       (wr),
      .busy     (busy),
      .dst_data (dst_data),
      .src_data (src_data)
   );

   fsac_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .fire     (exe_fire),
      .req      (exe_req_ff),
      .dst_data (dst_data),
      .src_data (src_data),
      .wr       (wr),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            exe_valid_ff <= 1'b1;
         end else if (exe_fire) begin
            exe_valid_ff <= 1'b0;
         end
         if (exe_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         exe_req_ff <= req;
      end
      if (exe_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("request transfer accepted during flag clear");

   a_accept_enters_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> exe_valid_ff)
      else $error("accepted request lost before execute");

   a_exec_makes_response: assert property (@(posedge clock) disable iff (reset)
      exe_fire |=> rsp_tvalid)
      else $error("executed request gave no response");

   a_sign_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({rsp_data_ff.acc_zero, rsp_data_ff.acc_positive,
                                 rsp_data_ff.acc_negative}) == 1)
      else $error("accumulator sign flags not exclusive");
`endif

endmodule
